[rtl/hbs_pkg.sv]
// Shared types and constants for the hash bucket store.
`timescale 1ns / 1ps
package hbs_pkg;
	localparam int MAX_ENTRIES = 8;
	localparam int KEY_BITS    = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int SIZE_W      = 4;
	localparam int DEPTH_W     = 5;
	localparam int CMD_W       = 3;
	localparam int SLOT_W      = 3;
	localparam int FS_W        = 4;

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PREFIX = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

	localparam logic REG_BUCKET_SIZE = 1'b0;
	localparam logic REG_DEPTH_BITS  = 1'b1;

	localparam logic signed [FS_W-1:0] FS_NONE = -4'sd1;

	typedef struct packed {
		logic valid;
		logic write_en;
		logic shift_en;
		logic last;
	} hbs_cell_ctl_t;
endpackage

[rtl/hbs_cell.sv]
// One key slot of the bucket: holds a key, compares it and shifts from its right neighbor.
`timescale 1ns / 1ps
module hbs_cell (
	input  logic                          clk,
	input  hbs_pkg::hbs_cell_ctl_t        ctl,
	input  logic [hbs_pkg::KEY_BITS-1:0]  key,
	input  logic [hbs_pkg::KEY_BITS-1:0]  next_key,
	input  logic                          found_prev,
	output logic [hbs_pkg::KEY_BITS-1:0]  stored_key,
	output logic                          first_hit,
	output logic                          found_chain
);
	logic [hbs_pkg::KEY_BITS-1:0] key_q;
	logic                         hit;

	assign hit         = ctl.valid && (key_q == key);
	assign first_hit   = hit && !found_prev;
	assign found_chain = found_prev || hit;
	assign stored_key  = key_q;

	always_ff @(posedge clk) begin
		if (ctl.write_en) begin
			key_q <= key;
		end else if (ctl.shift_en && found_chain) begin
			key_q <= ctl.last ? '0 : next_key;
		end
	end
endmodule

[rtl/hash_bucket_store_core.sv]
// Top level of the hash bucket store: command decode, cell row, status and APB registers.
`timescale 1ns / 1ps
// One bucket of an extendible hash table holding up to 8 keys of 16 bits in a row of
// cells, one cell per slot; each cell compares its key with the request key and passes
// a found flag and its key to its neighbor, so search, remove with left shift, insert,
// prefix check and slot read all resolve combinationally in the row. busy stays low: a request is
// taken every cycle, and its result appears with done high in the following cycle.
// Results cannot be held off, so the receiver must take each one when done is high.
// Registers: bucket_size at 0x0, depth_bits at 0x4. Slots never written read back
// as undefined.
module hash_bucket_store_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [hbs_pkg::CMD_W-1:0]           command,
	input  logic [hbs_pkg::KEY_BITS-1:0]        key,
	input  logic [hbs_pkg::SLOT_W-1:0]          slot,
	output logic                                done,
	output logic                                ok,
	output logic signed [hbs_pkg::FS_W-1:0]     found_slot,
	output logic [hbs_pkg::KEY_BITS-1:0]        read_key,
	output logic                                is_full,
	output logic                                is_empty,
	output logic [hbs_pkg::CNT_W-1:0]           entry_count,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	localparam int N = hbs_pkg::MAX_ENTRIES;

	logic [hbs_pkg::SIZE_W-1:0]   bucket_size_q;
	logic [hbs_pkg::DEPTH_W-1:0]  depth_bits_q;
	logic [hbs_pkg::CNT_W-1:0]    count_q;
	logic [hbs_pkg::CNT_W-1:0]    count_next;
	logic [hbs_pkg::SIZE_W-1:0]   cap;
	logic [hbs_pkg::DEPTH_W-1:0]  depth_eff;
	logic [hbs_pkg::KEY_BITS-1:0] prefix_mask;

	hbs_pkg::hbs_cell_ctl_t       ctl [N];
	logic [hbs_pkg::KEY_BITS-1:0] cell_key [N];
	logic [hbs_pkg::KEY_BITS-1:0] next_key [N];
	logic [N:0]                   found_chain;
	logic [N-1:0]                 first_hit;
	logic [hbs_pkg::IDX_W-1:0]    hit_idx;
	logic                         any_hit;

	logic accept;
	logic insert_go;
	logic remove_go;
	logic cfg_wr;

	logic                              ok_next;
	logic signed [hbs_pkg::FS_W-1:0]   fs_next;
	logic [hbs_pkg::KEY_BITS-1:0]      rk_next;

	logic                              done_q;
	logic                              ok_q;
	logic signed [hbs_pkg::FS_W-1:0]   found_slot_q;
	logic [hbs_pkg::KEY_BITS-1:0]      read_key_q;
	logic                              is_full_q;
	logic                              is_empty_q;
	logic [hbs_pkg::CNT_W-1:0]         entry_count_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_size_q <= hbs_pkg::SIZE_W'(1);
			depth_bits_q  <= hbs_pkg::DEPTH_W'(1);
		end else if (cfg_wr) begin
			case (paddr[2])
				hbs_pkg::REG_BUCKET_SIZE: bucket_size_q <= pwdata[hbs_pkg::SIZE_W-1:0];
				hbs_pkg::REG_DEPTH_BITS:  depth_bits_q  <= pwdata[hbs_pkg::DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			hbs_pkg::REG_BUCKET_SIZE: prdata = 32'(bucket_size_q);
			hbs_pkg::REG_DEPTH_BITS:  prdata = 32'(depth_bits_q);
			default:                  prdata = '0;
		endcase
	end

	assign cap = (bucket_size_q > hbs_pkg::SIZE_W'(N)) ? hbs_pkg::SIZE_W'(N) : bucket_size_q;
	assign depth_eff = (depth_bits_q > hbs_pkg::DEPTH_W'(hbs_pkg::KEY_BITS))
		? hbs_pkg::DEPTH_W'(hbs_pkg::KEY_BITS) : depth_bits_q;
	assign prefix_mask = ~({hbs_pkg::KEY_BITS{1'b1}} >> depth_eff);

	assign insert_go = accept && (command == hbs_pkg::CMD_INSERT)
		&& (hbs_pkg::SIZE_W'(count_q) < cap);
	assign remove_go = accept && (command == hbs_pkg::CMD_REMOVE);

	always_comb begin
		for (int i = 0; i < N; i++) begin
			ctl[i].valid    = hbs_pkg::CNT_W'(i) < count_q;
			ctl[i].write_en = insert_go && (count_q == hbs_pkg::CNT_W'(i));
			ctl[i].shift_en = remove_go && (hbs_pkg::CNT_W'(i) < count_q);
			ctl[i].last     = count_q == hbs_pkg::CNT_W'(i + 1);
			next_key[i]     = (i + 1 < N) ? cell_key[(i + 1) % N] : '0;
		end
	end

	assign found_chain[0] = 1'b0;

	for (genvar g = 0; g < N; g++) begin : g_cell
		hbs_cell u_cell (
			.clk         (clk),
			.ctl         (ctl[g]),
			.key         (key),
			.next_key    (next_key[g]),
			.found_prev  (found_chain[g]),
			.stored_key  (cell_key[g]),
			.first_hit   (first_hit[g]),
			.found_chain (found_chain[g + 1])
		);
	end

	assign any_hit = found_chain[N];

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (first_hit[i]) begin
				hit_idx = hit_idx | hbs_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		count_next = count_q;
		if (insert_go) begin
			count_next = count_q + 1'b1;
		end else if (remove_go && any_hit) begin
			count_next = count_q - 1'b1;
		end
	end

	always_comb begin
		ok_next = 1'b0;
		fs_next = hbs_pkg::FS_NONE;
		rk_next = '0;
		case (command)
			hbs_pkg::CMD_INSERT: ok_next = insert_go;
			hbs_pkg::CMD_SEARCH: begin
				if (any_hit) begin
					fs_next = hbs_pkg::FS_W'(hit_idx);
				end
			end
			hbs_pkg::CMD_REMOVE: ok_next = any_hit;
			hbs_pkg::CMD_PREFIX: begin
				ok_next = (count_q != '0) && (((key ^ cell_key[0]) & prefix_mask) == '0);
			end
			hbs_pkg::CMD_READ: begin
				if (32'(slot) < 32'(N)) begin
					rk_next = cell_key[slot[hbs_pkg::IDX_W-1:0]];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q          <= ok_next;
			found_slot_q  <= fs_next;
			read_key_q    <= rk_next;
			is_full_q     <= hbs_pkg::SIZE_W'(count_next) >= cap;
			is_empty_q    <= count_next == '0;
			entry_count_q <= count_next;
		end
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign found_slot  = found_slot_q;
	assign read_key    = read_key_q;
	assign is_full     = is_full_q;
	assign is_empty    = is_empty_q;
	assign entry_count = entry_count_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("request without result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= hbs_pkg::CNT_W'(N))
		else $error("entry count above bucket depth");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		insert_go |=> (count_q == $past(count_q) + 1'b1) && ok)
		else $error("insert did not advance count");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(remove_go && any_hit) |=> (count_q == $past(count_q) - 1'b1) && ok)
		else $error("remove did not drop count");

	a_first_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_hit) && (any_hit == (first_hit != '0)))
		else $error("match chain inconsistent");
endmodule
